FILE: src/gda_pkg.sv
// Shared types, constants and calendar helper functions for the Gregorian date adder.
`timescale 1ns / 1ps

package gda_pkg;

   // Unit selected by the request.
   typedef enum logic [2:0] {
      MODE_DAYS       = 3'd0,
      MODE_WEEKS      = 3'd1,
      MODE_MONTHS     = 3'd2,
      MODE_YEARS      = 3'd3,
      MODE_RAW_YEARS  = 3'd4,
      MODE_DECADES    = 3'd5,
      MODE_CENTURIES  = 3'd6,
      MODE_MILLENNIA  = 3'd7
   } mode_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_QUO,
      ST_CHECK,
      ST_YEAR,
      ST_STEP,
      ST_FINISH
   } state_type;

   localparam int DAY_W   = 5;
   localparam int MONTH_W = 4;
   localparam int YEAR_W  = 14;
   localparam int MODE_W  = 3;

   localparam logic [YEAR_W-1:0]  MAX_YEAR  = 14'd9999;
   localparam logic [MONTH_W-1:0] JANUARY   = 4'd1;
   localparam logic [MONTH_W-1:0] FEBRUARY  = 4'd2;
   localparam logic [MONTH_W-1:0] DECEMBER  = 4'd12;
   localparam logic [DAY_W-1:0]   FIRST_DAY = 5'd1;
   localparam logic [DAY_W-1:0]   FEB_SHORT = 5'd28;
   localparam logic [DAY_W-1:0]   FEB_LONG  = 5'd29;
   localparam logic [DAY_W-1:0]   LEN_SHORT = 5'd30;
   localparam logic [DAY_W-1:0]   LEN_LONG  = 5'd31;

   // Year within its century (0..99) and century modulo four.
   localparam int C100_W = 7;
   localparam int CEN_W  = 2;
   localparam logic [C100_W-1:0] LAST_C100 = 7'd99;

   // The shared multiplier: a year or count operand times a 13-bit operand.
   localparam int MUL_B_W = 13;

   // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year.
   localparam logic [MUL_B_W-1:0] RECIP_100   = 13'd5243;
   localparam int                 RECIP_SHIFT = 19;
   localparam int                 QUO_W       = 8;
   localparam logic [MUL_B_W-1:0] HUNDRED     = 13'd100;

   localparam logic [MUL_B_W-1:0] MULT_ONE      = 13'd1;
   localparam logic [MUL_B_W-1:0] MULT_TEN      = 13'd10;
   localparam logic [MUL_B_W-1:0] MULT_HUNDRED  = 13'd100;
   localparam logic [MUL_B_W-1:0] MULT_THOUSAND = 13'd1000;

   // Leap rule of 4, 100 and 400 from the year's residues.
   function automatic logic is_leap(input logic [1:0]        y4,
                                    input logic [C100_W-1:0] c100,
                                    input logic [CEN_W-1:0]  cen);
      return ((y4 == 2'd0) && (c100 != '0)) || ((c100 == '0) && (cen == '0));
   endfunction

   // Length of a month, zero for a month number that names no month.
   function automatic logic [DAY_W-1:0] month_len(input logic               leap,
                                                  input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd2:                      len = leap ? FEB_LONG : FEB_SHORT;
         4'd4, 4'd6, 4'd9, 4'd11:   len = LEN_SHORT;
         4'd1, 4'd3, 4'd5, 4'd7,
         4'd8, 4'd10, 4'd12:        len = LEN_LONG;
         default:                   len = '0;
      endcase
      return len;
   endfunction

   // Years per unit for the year modes.
   function automatic logic [MUL_B_W-1:0] mode_mult(input mode_type mode);
      logic [MUL_B_W-1:0] mult;
      case (mode)
         MODE_DECADES:   mult = MULT_TEN;
         MODE_CENTURIES: mult = MULT_HUNDRED;
         MODE_MILLENNIA: mult = MULT_THOUSAND;
         default:        mult = MULT_ONE;
      endcase
      return mult;
   endfunction

endpackage

FILE: src/gregorian_date_adder_core.sv
// Gregorian date adder: advances a date by days, weeks, months or years.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, count, start_day/month/year
// rsp_      out        rsp_valid/rsp_stall  new_day/month/year, year_overflow, bad_date
//
// A request passes through setup (two passes through the shared multiplier to split
// the year into century and year-of-century, then the date check), then through the
// calendar walk or, in the year modes, one year addition, and a finishing state. The
// day, week and month modes walk the calendar one step per cycle; the setup and the
// year modes use the shared 15x13 multiplier.
// Overflow ends a walk early. An invalid date or a zero count finishes after setup.
// Reset is synchronous and clears the sequencer and the result valid; no clearing pass.
// req_stall is high from acceptance until the result is loaded into the output register,
// so a new request may be taken while the previous result still waits under rsp_stall.
module gregorian_date_adder_core #(
   parameter int COUNT_BITS = 15
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gda_pkg::MODE_W-1:0]    req_mode,
   input  logic [COUNT_BITS-1:0]         req_count,
   input  logic [gda_pkg::DAY_W-1:0]     req_start_day,
   input  logic [gda_pkg::MONTH_W-1:0]   req_start_month,
   input  logic [gda_pkg::YEAR_W-1:0]    req_start_year,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gda_pkg::DAY_W-1:0]     rsp_new_day,
   output logic [gda_pkg::MONTH_W-1:0]   rsp_new_month,
   output logic [gda_pkg::YEAR_W-1:0]    rsp_new_year,
   output logic                          rsp_year_overflow,
   output logic                          rsp_bad_date
);

   // Step counter holds up to seven times the count.
   localparam int STEP_W  = COUNT_BITS + 3;
   // The multiplier's wide operand carries either the count or the year.
   localparam int MUL_A_W = (COUNT_BITS > gda_pkg::YEAR_W) ? COUNT_BITS : gda_pkg::YEAR_W;
   localparam int PROD_W  = MUL_A_W + gda_pkg::MUL_B_W;
   localparam int SUM_W   = PROD_W + 1;

   gda_pkg::state_type state_ff, state_in;

   gda_pkg::mode_type                  mode_ff, mode_in;
   logic [COUNT_BITS-1:0]              count_ff, count_in;
   logic [STEP_W-1:0]                  steps_ff, steps_in;
   logic [gda_pkg::DAY_W-1:0]          day_ff, day_in;
   logic [gda_pkg::MONTH_W-1:0]        month_ff, month_in;
   logic [gda_pkg::YEAR_W-1:0]         year_ff, year_in;
   logic [gda_pkg::C100_W-1:0]         c100_ff, c100_in;
   logic [gda_pkg::CEN_W-1:0]          cen_ff, cen_in;
   logic [gda_pkg::QUO_W-1:0]          quo_ff, quo_in;
   logic [PROD_W-1:0]                  prod_ff;
   logic                               ovf_ff, ovf_in;
   logic                               bad_ff, bad_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [gda_pkg::DAY_W-1:0]          rsp_day_ff;
   logic [gda_pkg::MONTH_W-1:0]        rsp_month_ff;
   logic [gda_pkg::YEAR_W-1:0]         rsp_year_ff;
   logic                               rsp_ovf_ff;
   logic                               rsp_bad_ff;

   // Shared multiplier operands, selected by the sequencer.
   logic [MUL_A_W-1:0]                 mul_a;
   logic [gda_pkg::MUL_B_W-1:0]        mul_b;

   logic                               req_take;
   logic                               out_free;
   logic                               load_rsp;

   // Date check in the setup's last cycle.
   logic [gda_pkg::YEAR_W-1:0]         c100_wide;
   logic [gda_pkg::C100_W-1:0]         c100_chk;
   logic                               leap_chk;
   logic [gda_pkg::DAY_W-1:0]          mlen_chk;
   logic                               bad_chk;
   logic                               no_work;

   // One calendar step.
   logic                               leap_cur;
   logic [gda_pkg::DAY_W-1:0]          mlen_cur;
   logic [gda_pkg::YEAR_W-1:0]         year_nx;
   logic [gda_pkg::C100_W-1:0]         c100_nx;
   logic [gda_pkg::CEN_W-1:0]          cen_nx;
   logic                               year_wrap;
   logic                               at_max_year;
   logic                               last_step;

   // Year mode sum.
   logic [SUM_W-1:0]                   year_sum;
   logic                               year_sat;

   assign req_stall = (state_ff != gda_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load_rsp  = (state_ff == gda_pkg::ST_FINISH) && out_free;

   // The second multiplier pass leaves quotient * 100 in the product register, so the
   // year within its century is the low bits of the difference.
   assign c100_wide = year_ff - prod_ff[gda_pkg::YEAR_W-1:0];
   assign c100_chk  = c100_wide[gda_pkg::C100_W-1:0];
   assign leap_chk  = gda_pkg::is_leap(year_ff[1:0], c100_chk, quo_ff[gda_pkg::CEN_W-1:0]);
   assign mlen_chk  = gda_pkg::month_len(leap_chk, month_ff);
   assign bad_chk   = (mlen_chk == '0) || (day_ff == '0) || (day_ff > mlen_chk)
                      || (year_ff > gda_pkg::MAX_YEAR);
   assign no_work   = bad_chk || (steps_ff == '0);

   // The year residues move along with the year, so the leap rule never needs a divide.
   assign leap_cur    = gda_pkg::is_leap(year_ff[1:0], c100_ff, cen_ff);
   assign mlen_cur    = gda_pkg::month_len(leap_cur, month_ff);
   assign year_nx     = year_ff + 1'b1;
   assign year_wrap   = (c100_ff == gda_pkg::LAST_C100);
   assign c100_nx     = year_wrap ? '0 : c100_ff + 1'b1;
   assign cen_nx      = year_wrap ? cen_ff + 1'b1 : cen_ff;
   assign at_max_year = (year_ff >= gda_pkg::MAX_YEAR);
   assign last_step   = (steps_ff == STEP_W'(1));

   assign year_sum = SUM_W'(year_ff) + SUM_W'(prod_ff);
   assign year_sat = (year_sum > SUM_W'(gda_pkg::MAX_YEAR));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gda_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = gda_pkg::ST_DIV;
            end
         end
         gda_pkg::ST_DIV: begin
            state_in = gda_pkg::ST_QUO;
         end
         gda_pkg::ST_QUO: begin
            state_in = gda_pkg::ST_CHECK;
         end
         gda_pkg::ST_CHECK: begin
            if (no_work) begin
               state_in = gda_pkg::ST_FINISH;
            end else if (mode_ff inside {gda_pkg::MODE_DAYS, gda_pkg::MODE_WEEKS,
                                         gda_pkg::MODE_MONTHS}) begin
               state_in = gda_pkg::ST_STEP;
            end else begin
               state_in = gda_pkg::ST_YEAR;
            end
         end
         gda_pkg::ST_YEAR: begin
            state_in = gda_pkg::ST_FINISH;
         end
         gda_pkg::ST_STEP: begin
            if (last_step || ((month_ff == gda_pkg::DECEMBER) && at_max_year
                && ((mode_ff == gda_pkg::MODE_MONTHS) || (day_ff == mlen_cur)))) begin
               state_in = gda_pkg::ST_FINISH;
            end
         end
         gda_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = gda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gda_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath: what each state does with the working date and the multiplier.
   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      steps_in = steps_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      c100_in  = c100_ff;
      cen_in   = cen_ff;
      quo_in   = quo_ff;
      ovf_in   = ovf_ff;
      bad_in   = bad_ff;
      mul_a    = '0;
      mul_b    = '0;
      case (state_ff)
         gda_pkg::ST_IDLE: begin
            if (req_take) begin
               mode_in  = gda_pkg::mode_type'(req_mode);
               count_in = req_count;
               if (gda_pkg::mode_type'(req_mode) == gda_pkg::MODE_WEEKS) begin
                  // Seven times the count as eight times less one.
                  steps_in = {req_count, 3'b000} - STEP_W'(req_count);
               end else begin
                  steps_in = STEP_W'(req_count);
               end
               day_in   = req_start_day;
               month_in = req_start_month;
               year_in  = req_start_year;
               ovf_in   = 1'b0;
               bad_in   = 1'b0;
            end
         end
         gda_pkg::ST_DIV: begin
            mul_a = MUL_A_W'(year_ff);
            mul_b = gda_pkg::RECIP_100;
         end
         gda_pkg::ST_QUO: begin
            quo_in = prod_ff[gda_pkg::RECIP_SHIFT +: gda_pkg::QUO_W];
            mul_a  = MUL_A_W'(prod_ff[gda_pkg::RECIP_SHIFT +: gda_pkg::QUO_W]);
            mul_b  = gda_pkg::HUNDRED;
         end
         gda_pkg::ST_CHECK: begin
            c100_in = c100_chk;
            cen_in  = quo_ff[gda_pkg::CEN_W-1:0];
            bad_in  = bad_chk;
            mul_a   = MUL_A_W'(count_ff);
            mul_b   = gda_pkg::mode_mult(mode_ff);
         end
         gda_pkg::ST_YEAR: begin
            if (year_sat) begin
               year_in = gda_pkg::MAX_YEAR;
               ovf_in  = 1'b1;
            end else begin
               year_in = year_sum[gda_pkg::YEAR_W-1:0];
            end
            // In year mode February 29 always becomes the 28th, even when the new year is a leap year.
            if ((mode_ff == gda_pkg::MODE_YEARS) && (month_ff == gda_pkg::FEBRUARY)
                && (day_ff > gda_pkg::FEB_SHORT)) begin
               day_in = gda_pkg::FEB_SHORT;
            end
         end
         gda_pkg::ST_STEP: begin
            steps_in = steps_ff - 1'b1;
            if (mode_ff == gda_pkg::MODE_MONTHS) begin
               if (month_ff == gda_pkg::DECEMBER) begin
                  if (at_max_year) begin
                     day_in   = gda_pkg::LEN_LONG;
                     month_in = gda_pkg::DECEMBER;
                     year_in  = gda_pkg::MAX_YEAR;
                     ovf_in   = 1'b1;
                  end else begin
                     month_in = gda_pkg::JANUARY;
                     year_in  = year_nx;
                     c100_in  = c100_nx;
                     cen_in   = cen_nx;
                     // January is never short, so the day stands.
                  end
               end else begin
                  month_in = month_ff + 1'b1;
                  if (day_ff > gda_pkg::month_len(leap_cur, month_ff + 1'b1)) begin
                     day_in = gda_pkg::month_len(leap_cur, month_ff + 1'b1);
                  end
               end
            end else begin
               if (day_ff == mlen_cur) begin
                  day_in = gda_pkg::FIRST_DAY;
                  if (month_ff == gda_pkg::DECEMBER) begin
                     if (at_max_year) begin
                        day_in   = gda_pkg::LEN_LONG;
                        month_in = gda_pkg::DECEMBER;
                        year_in  = gda_pkg::MAX_YEAR;
                        ovf_in   = 1'b1;
                     end else begin
                        month_in = gda_pkg::JANUARY;
                        year_in  = year_nx;
                        c100_in  = c100_nx;
                        cen_in   = cen_nx;
                     end
                  end else begin
                     month_in = month_ff + 1'b1;
                  end
               end else begin
                  day_in = day_ff + 1'b1;
               end
            end
         end
         gda_pkg::ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gda_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff  <= mode_in;
      count_ff <= count_in;
      steps_ff <= steps_in;
      day_ff   <= day_in;
      month_ff <= month_in;
      year_ff  <= year_in;
      c100_ff  <= c100_in;
      cen_ff   <= cen_in;
      quo_ff   <= quo_in;
      ovf_ff   <= ovf_in;
      bad_ff   <= bad_in;
      prod_ff  <= PROD_W'(mul_a) * PROD_W'(mul_b);
      if (load_rsp) begin
         rsp_day_ff   <= day_ff;
         rsp_month_ff <= month_ff;
         rsp_year_ff  <= year_ff;
         rsp_ovf_ff   <= ovf_ff;
         rsp_bad_ff   <= bad_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_new_day       = rsp_day_ff;
   assign rsp_new_month     = rsp_month_ff;
   assign rsp_new_year      = rsp_year_ff;
   assign rsp_year_overflow = rsp_ovf_ff;
   assign rsp_bad_date      = rsp_bad_ff;

   // A result only appears straight after the sequencer finished a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == gda_pkg::ST_FINISH))
      else $error("result appeared without a finished request");

   // The walk never runs with no steps left.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_STEP) |-> (steps_ff != '0))
      else $error("calendar walk entered with an empty step count");

   // The year-of-century residue stays in range while walking.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == gda_pkg::ST_STEP) |-> (c100_ff <= gda_pkg::LAST_C100))
      else $error("year residue out of range");

   // An invalid date never reports an overflow.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_bad_date && rsp_year_overflow))
      else $error("bad date and overflow flagged together");

   // A valid date never comes out past the last year.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_bad_date) |-> (rsp_new_year <= gda_pkg::MAX_YEAR))
      else $error("result year above the last year");

endmodule

FILE: tb/gregorian_date_adder_core_tb.sv
// Self-checking testbench for the Gregorian date adder core with its own date predictor.
`timescale 1ns / 1ps

module gregorian_date_adder_core_tb;

   localparam int COUNT_BITS  = 15;
   localparam int LAST_YEAR   = 9999;
   // The slowest request is a full week-mode walk, and the directed part holds a few
   // long walks. Everything else is small, so the limit is several times the slowest
   // clean run.
   localparam int CYCLE_LIMIT = 2000000;
   // Long enough to fill the output register and the sequencer behind it.
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 40;

   // One result of the block, as the response channel carries it.
   typedef struct {
      logic [gda_pkg::DAY_W-1:0]   day;
      logic [gda_pkg::MONTH_W-1:0] month;
      logic [gda_pkg::YEAR_W-1:0]  year;
      logic                        overflow;
      logic                        bad;
   } date_result_type;

   // The scoreboard predicts the advanced date for every accepted request and keeps
   // the predictions in order until the matching response arrives.
   class date_scoreboard_type;
      date_result_type expected_dates[$];
      int              errors = 0;

      static function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function int unsigned days_in_month(int unsigned y, int unsigned m);
         if (m < 1 || m > 12) return 0;
         if (m == 2) return leap_year(y) ? 29 : 28;
         if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
         return 31;
      endfunction

      static function date_result_type advance_date(gda_pkg::mode_type mode,
                                                    int unsigned count,
                                                    int unsigned day, int unsigned month,
                                                    int unsigned year);
         date_result_type r;
         int unsigned     d, m, y, steps, mult;
         bit              ovf, bad;
         d = day;
         m = month;
         y = year;
         ovf = 1'b0;
         bad = 1'b0;
         if (m < 1 || m > 12 || d < 1 || d > days_in_month(y, m) || y > LAST_YEAR) begin
            bad = 1'b1;
         end else if (count != 0) begin
            if (mode == gda_pkg::MODE_DAYS || mode == gda_pkg::MODE_WEEKS) begin
               steps = (mode == gda_pkg::MODE_WEEKS) ? count * 7 : count;
               for (int unsigned i = 0; i < steps; i++) begin
                  if (d == days_in_month(y, m)) begin
                     d = 1;
                     if (m == 12) begin
                        // Walking past the last day of the last year saturates.
                        if (y >= LAST_YEAR) begin
                           d = 31;
                           y = LAST_YEAR;
                           ovf = 1'b1;
                           break;
                        end
                        m = 1;
                        y++;
                     end else begin
                        m++;
                     end
                  end else begin
                     d++;
                  end
               end
            end else if (mode == gda_pkg::MODE_MONTHS) begin
               for (int unsigned i = 0; i < count; i++) begin
                  if (m == 12) begin
                     if (y >= LAST_YEAR) begin
                        d = 31;
                        y = LAST_YEAR;
                        ovf = 1'b1;
                        break;
                     end
                     m = 1;
                     y++;
                  end else begin
                     m++;
                  end
                  // The day is cut to every month passed through, not only the last.
                  if (d > days_in_month(y, m)) d = days_in_month(y, m);
               end
            end else begin
               case (mode)
                  gda_pkg::MODE_DECADES:   mult = 10;
                  gda_pkg::MODE_CENTURIES: mult = 100;
                  gda_pkg::MODE_MILLENNIA: mult = 1000;
                  default:                 mult = 1;
               endcase
               y += count * mult;
               if (y > LAST_YEAR) begin
                  y = LAST_YEAR;
                  ovf = 1'b1;
               end
               // Year mode always turns a leap day into the 28th.
               if (mode == gda_pkg::MODE_YEARS && m == 2 && d > 28) d = 28;
            end
         end
         r.day      = d[gda_pkg::DAY_W-1:0];
         r.month    = m[gda_pkg::MONTH_W-1:0];
         r.year     = y[gda_pkg::YEAR_W-1:0];
         r.overflow = ovf;
         r.bad      = bad;
         return r;
      endfunction

      function void note_request(gda_pkg::mode_type mode, int unsigned count,
                                 int unsigned day, int unsigned month, int unsigned year);
         expected_dates.push_back(advance_date(mode, count, day, month, year));
      endfunction

      function void check_result(date_result_type got);
         date_result_type want;
         if (expected_dates.size() == 0) begin
            $error("response with no request outstanding: %0d/%0d/%0d",
                   got.day, got.month, got.year);
            errors++;
            return;
         end
         want = expected_dates.pop_front();
         if (got.day !== want.day) begin
            $error("new_day: expected %0d, got %0d", want.day, got.day);
            errors++;
         end
         if (got.month !== want.month) begin
            $error("new_month: expected %0d, got %0d", want.month, got.month);
            errors++;
         end
         if (got.year !== want.year) begin
            $error("new_year: expected %0d, got %0d", want.year, got.year);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $error("year_overflow: expected %0d, got %0d", want.overflow, got.overflow);
            errors++;
         end
         if (got.bad !== want.bad) begin
            $error("bad_date: expected %0d, got %0d", want.bad, got.bad);
            errors++;
         end
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   // All block inputs start at known values.
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [gda_pkg::MODE_W-1:0]    req_mode = '0;
   logic [COUNT_BITS-1:0]         req_count = '0;
   logic [gda_pkg::DAY_W-1:0]     req_start_day = '0;
   logic [gda_pkg::MONTH_W-1:0]   req_start_month = '0;
   logic [gda_pkg::YEAR_W-1:0]    req_start_year = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [gda_pkg::DAY_W-1:0]     rsp_new_day;
   logic [gda_pkg::MONTH_W-1:0]   rsp_new_month;
   logic [gda_pkg::YEAR_W-1:0]    rsp_new_year;
   logic                          rsp_year_overflow;
   logic                          rsp_bad_date;

   // Idle rates in percent; the sender's is read only by the main process, the
   // receiver's is written with nonblocking assignments so its process sees it cleanly.
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   // The main process asks for a long receiver hold-off by bumping hold_requests;
   // the receiver process counts the stretch down itself.
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int cycles        = 0;

   date_scoreboard_type sb;

   gregorian_date_adder_core #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_count(req_count),
      .req_start_day(req_start_day),
      .req_start_month(req_start_month),
      .req_start_year(req_start_year),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_new_day(rsp_new_day),
      .rsp_new_month(rsp_new_month),
      .rsp_new_year(rsp_new_year),
      .rsp_year_overflow(rsp_year_overflow),
      .rsp_bad_date(rsp_bad_date)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Receiver: random stalls, or a long hold-off when one has been asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_stall   <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
      end
   end

   // A response moves at an edge where valid is high and stall is low; both are
   // sampled here before this edge's updates take effect.
   always @(posedge clock) begin
      date_result_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.day      = rsp_new_day;
         got.month    = rsp_new_month;
         got.year     = rsp_new_year;
         got.overflow = rsp_year_overflow;
         got.bad      = rsp_bad_date;
         sb.check_result(got);
      end
   end

   // Offers one request, after a random idle gap, and holds it until it is taken.
   // Valid is left high afterwards so back-to-back requests need no gap.
   task automatic offer_request(gda_pkg::mode_type mode, int unsigned count,
                                int unsigned day, int unsigned month, int unsigned year);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_count       <= count[COUNT_BITS-1:0];
      req_start_day   <= day[gda_pkg::DAY_W-1:0];
      req_start_month <= month[gda_pkg::MONTH_W-1:0];
      req_start_year  <= year[gda_pkg::YEAR_W-1:0];
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(mode, count, day, month, year);
   endtask

   // Builds one random request. Most dates are valid and lean toward month ends,
   // century years, leap years and the last years before saturation; the rest are
   // raw field values. Walk modes mostly get short counts so the run stays short.
   task automatic random_request();
      gda_pkg::mode_type mode;
      int unsigned       count, day, month, year, len, pick;
      mode = gda_pkg::mode_type'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         day   = $urandom_range(0, 31);
         month = $urandom_range(0, 15);
         year  = $urandom_range(0, 16383);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 50)      year = $urandom_range(0, LAST_YEAR);
         else if (pick < 70) year = $urandom_range(LAST_YEAR - 9, LAST_YEAR);
         else if (pick < 85) year = $urandom_range(0, 99) * 100;
         else                year = $urandom_range(0, 2499) * 4;
         month = $urandom_range(1, 12);
         len   = date_scoreboard_type::days_in_month(year, month);
         pick  = $urandom_range(0, 99);
         if (pick < 35)      day = len;
         else if (pick < 45) day = len - 1;
         else                day = $urandom_range(1, len);
      end
      pick = $urandom_range(0, 99);
      if (mode >= gda_pkg::MODE_YEARS) begin
         count = (pick < 50) ? $urandom_range(0, 32767) : $urandom_range(0, 20);
      end else if (pick < 4) begin
         count = (mode == gda_pkg::MODE_WEEKS) ? $urandom_range(0, 400)
                                               : $urandom_range(0, 3000);
      end else begin
         count = $urandom_range(0, 40);
      end
      offer_request(mode, count, day, month, year);
   endtask

   initial begin
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed requests: zero count, month and year rollover, each leap rule, saturation in the
      // day, month, year, century and millennium modes, the longest walks and the invalid dates.
      offer_request(gda_pkg::MODE_DAYS,      0,     15, 6,  2020);
      offer_request(gda_pkg::MODE_DAYS,      1,     31, 12, 1999);
      offer_request(gda_pkg::MODE_DAYS,      1,     28, 2,  2000);
      offer_request(gda_pkg::MODE_DAYS,      1,     28, 2,  1900);
      offer_request(gda_pkg::MODE_DAYS,      2,     28, 2,  0);
      offer_request(gda_pkg::MODE_DAYS,      5,     30, 12, 9999);
      offer_request(gda_pkg::MODE_DAYS,      32767, 31, 1,  9950);
      offer_request(gda_pkg::MODE_WEEKS,     1,     25, 12, 2023);
      offer_request(gda_pkg::MODE_WEEKS,     32767, 1,  1,  0);
      offer_request(gda_pkg::MODE_MONTHS,    1,     31, 1,  2023);
      offer_request(gda_pkg::MODE_MONTHS,    1,     31, 1,  2024);
      offer_request(gda_pkg::MODE_MONTHS,    13,    31, 12, 9998);
      offer_request(gda_pkg::MODE_MONTHS,    32767, 15, 3,  0);
      offer_request(gda_pkg::MODE_YEARS,     4,     29, 2,  2020);
      offer_request(gda_pkg::MODE_YEARS,     32767, 29, 2,  0);
      offer_request(gda_pkg::MODE_RAW_YEARS, 1,     29, 2,  2024);
      offer_request(gda_pkg::MODE_DECADES,   999,   1,  1,  9);
      offer_request(gda_pkg::MODE_CENTURIES, 100,   5,  5,  0);
      offer_request(gda_pkg::MODE_MILLENNIA, 10,    31, 12, 0);
      offer_request(gda_pkg::MODE_DAYS,      3,     10, 0,  2000);
      offer_request(gda_pkg::MODE_MILLENNIA, 32767, 31, 15, 16383);
      offer_request(gda_pkg::MODE_MONTHS,    1,     0,  6,  2020);
      offer_request(gda_pkg::MODE_WEEKS,     2,     31, 4,  2021);
      offer_request(gda_pkg::MODE_YEARS,     1,     29, 2,  1900);
      offer_request(gda_pkg::MODE_RAW_YEARS, 1,     1,  1,  10000);

      // Mostly busy sender into a mostly stalled receiver.
      send_idle_pct = 9;
      rsp_idle_pct <= 75;
      repeat (25) random_request();

      // Mostly idle sender into a mostly ready receiver.
      send_idle_pct = 75;
      rsp_idle_pct <= 9;
      repeat (25) random_request();

      // Full rate on both sides, opened by a long receiver hold-off so the result
      // register and the sequencer both fill and the block stalls its requests.
      send_idle_pct = 0;
      rsp_idle_pct  <= 0;
      hold_requests <= hold_requests + 1;
      repeat (25) random_request();
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      // Any stray extra response would show up during the drain.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/gda_pkg.sv
src/gregorian_date_adder_core.sv
tb/gregorian_date_adder_core_tb.sv
